// ===== hdl/ncd_pkg.sv =====
package ncd_pkg;

    // Fixed field widths
    localparam int unsigned TABLE_W = 64;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned LAYER_W = 6;
    localparam int unsigned TESTS   = 6;
    localparam int unsigned HALF_W  = TABLE_W / 2;

    typedef struct packed {
        logic [TABLE_W-1:0] truth_table;
        logic [COUNT_W-1:0] num_inputs;
    } ncd_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] depth;
        logic [LAYER_W-1:0] canal_inputs;
        logic [LAYER_W-1:0] canal_outputs;
        logic [TABLE_W-1:0] remaining_table;
    } ncd_result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ncd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;
    } ncd_status_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ncd_state_t;

    // Table positions whose index has bit i set
    localparam logic [TABLE_W-1:0] ON_PATTERN [TESTS] = '{
        64'hAAAA_AAAA_AAAA_AAAA,
        64'hCCCC_CCCC_CCCC_CCCC,
        64'hF0F0_F0F0_F0F0_F0F0,
        64'hFF00_FF00_FF00_FF00,
        64'hFFFF_0000_FFFF_0000,
        64'hFFFF_FFFF_0000_0000
    };

    // Mask of the 2^m live table entries
    function automatic logic [TABLE_W-1:0] valid_mask(input logic [COUNT_W-1:0] m);
        logic [TABLE_W-1:0] mask;
        case (m)
            3'd0:    mask = 64'h0000_0000_0000_0001;
            3'd1:    mask = 64'h0000_0000_0000_0003;
            3'd2:    mask = 64'h0000_0000_0000_000F;
            3'd3:    mask = 64'h0000_0000_0000_00FF;
            3'd4:    mask = 64'h0000_0000_0000_FFFF;
            3'd5:    mask = 64'h0000_0000_FFFF_FFFF;
            default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

// ===== hdl/ncd_ctrl.sv =====
module ncd_ctrl
    import ncd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    output logic        result_valid,
    input  logic        result_ready,
    input  ncd_status_t status,
    output ncd_cmd_t    cmd
);

    ncd_state_t state_reg, state_next;
    logic       valid_reg, valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.done)
                begin
                    cmd.step = 1'b1;
                end
                else if (!valid_reg || result_ready)
                begin
                    // output slot free or emptied this cycle
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    assign result_valid = valid_reg;

endmodule

// ===== hdl/ncd_datapath.sv =====
module ncd_datapath
    import ncd_pkg::*;
#(
    parameter int MAX_INPUTS = 6
)
(
    input  logic        clk,
    input  ncd_item_t   item,
    input  ncd_cmd_t    cmd,
    output ncd_status_t status,
    output ncd_result_t result
);

    logic [TABLE_W-1:0] table_reg, table_next;
    logic [COUNT_W-1:0] m_reg, m_next;
    logic [COUNT_W-1:0] depth_reg, depth_next;
    logic [LAYER_W-1:0] cins_reg, cins_next;
    logic [LAYER_W-1:0] couts_reg, couts_next;
    ncd_result_t        result_reg;

    logic [COUNT_W-1:0] m_load;
    logic [TESTS-1:0]   hit, cin, cout;
    logic [HALF_W-1:0]  packed_half [TESTS];
    logic               any_hit;
    logic               cin_sel, cout_sel;
    logic [HALF_W-1:0]  half_sel;

    // Saturate the input count on load
    assign m_load = (item.num_inputs > COUNT_W'(MAX_INPUTS)) ? COUNT_W'(MAX_INPUTS)
                                                             : item.num_inputs;

    // Canalizing tests on every input, plus the kept half for each
    always_comb
    begin
        logic [TABLE_W-1:0] live, onm, offm, on_bits, off_bits;
        logic [5:0]         j;
        live = valid_mask(m_reg);
        for (int i = 0; i < TESTS; i++)
        begin
            onm      = ON_PATTERN[i] & live;
            offm     = ~ON_PATTERN[i] & live;
            on_bits  = table_reg & onm;
            off_bits = table_reg & offm;
            hit[i]   = (COUNT_W'(i) < m_reg);
            if (on_bits == '0)
            begin
                cin[i] = 1'b1; cout[i] = 1'b0;
            end
            else if (on_bits == onm)
            begin
                cin[i] = 1'b1; cout[i] = 1'b1;
            end
            else if (off_bits == '0)
            begin
                cin[i] = 1'b0; cout[i] = 1'b0;
            end
            else if (off_bits == offm)
            begin
                cin[i] = 1'b0; cout[i] = 1'b1;
            end
            else
            begin
                cin[i] = 1'b0; cout[i] = 1'b0; hit[i] = 1'b0;
            end
            // keep entries whose bit i differs from the canalizing value
            for (int p = 0; p < HALF_W; p++)
            begin
                j = 6'(((p >> i) << (i + 1)) | (p & ((1 << i) - 1)));
                j[i] = ~cin[i];
                packed_half[i][p] = table_reg[j];
            end
        end
    end

    // Lowest canalizing input wins
    always_comb
    begin
        any_hit  = 1'b0;
        cin_sel  = 1'b0;
        cout_sel = 1'b0;
        half_sel = '0;
        for (int i = TESTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                any_hit  = 1'b1;
                cin_sel  = cin[i];
                cout_sel = cout[i];
                half_sel = packed_half[i];
            end
        end
    end

    assign status.done = (m_reg == '0) || !any_hit;

    // Next values of the working registers
    always_comb
    begin
        table_next = table_reg;
        m_next     = m_reg;
        depth_next = depth_reg;
        cins_next  = cins_reg;
        couts_next = couts_reg;
        if (cmd.load)
        begin
            table_next = item.truth_table & valid_mask(m_load);
            m_next     = m_load;
            depth_next = '0;
            cins_next  = '0;
            couts_next = '0;
        end
        else if (cmd.step)
        begin
            table_next = TABLE_W'(half_sel);
            m_next     = m_reg - 1'b1;
            depth_next = depth_reg + 1'b1;
            cins_next  = cins_reg | (LAYER_W'(cin_sel) << depth_reg);
            couts_next = couts_reg | (LAYER_W'(cout_sel) << depth_reg);
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        table_reg <= table_next;
        m_reg     <= m_next;
        depth_reg <= depth_next;
        cins_reg  <= cins_next;
        couts_reg <= couts_next;
        if (cmd.emit)
        begin
            result_reg.depth           <= depth_reg;
            result_reg.canal_inputs    <= cins_reg;
            result_reg.canal_outputs   <= couts_reg;
            result_reg.remaining_table <= table_reg;
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/nested_canalizing_depth.sv =====
// Each item is peeled one layer per cycle in the datapath; the result is registered once no input canalizes.
// A new item is taken only after the previous result has been emitted to the output register.
// A finished result waits in the output register while the next item is taken in.
// Reset (rst_n, async, active low) clears the controller state and result valid;
// data registers are not reset.
module nested_canalizing_depth
    import ncd_pkg::*;
#(
    parameter int MAX_INPUTS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  ncd_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output ncd_result_t result
);

    ncd_cmd_t    cmd;
    ncd_status_t status;

    ncd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    ncd_datapath #(
        .MAX_INPUTS (MAX_INPUTS)
    ) u_datapath (
        .clk    (clk),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // Busy after an item transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item taken while previous item in progress");

    // Depth never exceeds the input limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.depth <= COUNT_W'(MAX_INPUTS)))
        else $error("depth above input limit");

    // Layer bits at and above depth stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (((result.canal_inputs >> result.depth) == '0)
                      && ((result.canal_outputs >> result.depth) == '0)))
        else $error("layer bits set beyond depth");

    // A new result only after a step phase finished
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.done)
        else $error("result emitted before peeling finished");

endmodule
